/* rtl/encpm_pkg.sv */
// Package for the encoder position and limit monitor.
// Holds shared constants, operation codes and the structs passed between modules.
// No dependencies.
`default_nettype none

package encpm_pkg;

  // Number of debounced switches. Switches past the pin count see a level of 0.
  localparam int unsigned NUM_SWITCHES = 4;
  localparam int unsigned PIN_COUNT    = 4;

  localparam logic [15:0] AZ_MIDPOINT    = 16'h8000;
  localparam logic [31:0] EL_MIDPOINT    = 32'h8000_0000;
  localparam logic [31:0] DEBOUNCE_RESET = 32'd10;

  // Configuration port: word-addressed by paddr[2].
  localparam int unsigned CFG_ADDR_W       = 3;
  localparam logic        REG_DEBOUNCE_SEL = 1'b0;

  typedef enum logic [1:0] {
    OP_SAMPLE   = 2'd0,
    OP_AZ_INDEX = 2'd1,
    OP_EL_INDEX = 2'd2,
    OP_AZ_RESET = 2'd3
  } op_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [3:0]  switch_pins;
    logic [31:0] el_counter;
    logic [15:0] az_counter;
    op_t         op;
  } item_t;

  typedef struct packed {
    logic [15:0] el_index_count;
    logic [15:0] az_index_count;
    logic [31:0] el_position;
    logic [31:0] az_position;
  } axis_status_t;

  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 104;

endpackage : encpm_pkg

`default_nettype wire

/* rtl/encpm_axis.sv */
// Azimuth and elevation position tracking plus index pulse counters.
// Depends on encpm_pkg.
`default_nettype none

module encpm_axis (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   step,
  input  wire encpm_pkg::item_t       item,
  output encpm_pkg::axis_status_t     status
);
  import encpm_pkg::*;

  logic [15:0] az_last_r,   az_last_nxt;
  logic [31:0] az_acc_r,    az_acc_nxt;
  logic [31:0] el_pos_r,    el_pos_nxt;
  logic [15:0] az_index_r,  az_index_nxt;
  logic [15:0] el_index_r,  el_index_nxt;
  logic [15:0] az_diff;

  always_comb begin
    az_last_nxt  = az_last_r;
    az_acc_nxt   = az_acc_r;
    el_pos_nxt   = el_pos_r;
    az_index_nxt = az_index_r;
    el_index_nxt = el_index_r;
    // The counter difference is taken modulo 2^16 and sign extended.
    az_diff = item.az_counter - az_last_r;
    case (item.op)
      OP_SAMPLE: begin
        az_last_nxt = item.az_counter;
        az_acc_nxt  = az_acc_r + {{16{az_diff[15]}}, az_diff};
        el_pos_nxt  = EL_MIDPOINT - item.el_counter;
      end
      OP_AZ_INDEX: begin
        az_index_nxt = az_index_r + 16'd1;
      end
      OP_EL_INDEX: begin
        el_index_nxt = el_index_r + 16'd1;
      end
      OP_AZ_RESET: begin
        az_last_nxt = AZ_MIDPOINT;
        az_acc_nxt  = '0;
      end
      default: begin
        az_last_nxt = az_last_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      az_last_r  <= AZ_MIDPOINT;
      az_acc_r   <= '0;
      el_pos_r   <= '0;
      az_index_r <= '0;
      el_index_r <= '0;
    end else if (step) begin
      az_last_r  <= az_last_nxt;
      az_acc_r   <= az_acc_nxt;
      el_pos_r   <= el_pos_nxt;
      az_index_r <= az_index_nxt;
      el_index_r <= el_index_nxt;
    end
  end

  assign status.az_position    = az_acc_nxt;
  assign status.el_position    = el_pos_nxt;
  assign status.az_index_count = az_index_nxt;
  assign status.el_index_count = el_index_nxt;

endmodule : encpm_axis

`default_nettype wire

/* rtl/encpm_debounce.sv */
// Bank of limit switch debouncers, one timer and level register per switch.
// Depends on encpm_pkg.
`default_nettype none

module encpm_debounce (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  input  wire logic        sample,
  input  wire logic [3:0]  switch_pins,
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] debounce_ms,
  output logic [3:0]       limit_bits
);
  import encpm_pkg::*;

  logic [NUM_SWITCHES-1:0] stable_r, stable_nxt;
  logic [NUM_SWITCHES-1:0] last_raw_r, last_raw_nxt;
  logic [31:0]             change_time_r   [NUM_SWITCHES];
  logic [31:0]             change_time_nxt [NUM_SWITCHES];
  logic [NUM_SWITCHES-1:0] level;

  for (genvar k = 0; k < NUM_SWITCHES; k++) begin : g_sw
    logic [31:0] elapsed;

    // Pins are active low; switches without a pin never trigger.
    if (k < PIN_COUNT) begin : g_pin
      assign level[k] = ~switch_pins[k];
    end else begin : g_nopin
      assign level[k] = 1'b0;
    end

    assign elapsed = now_ms - change_time_r[k];

    always_comb begin
      stable_nxt[k]      = stable_r[k];
      last_raw_nxt[k]    = last_raw_r[k];
      change_time_nxt[k] = change_time_r[k];
      if (sample) begin
        if (level[k] != last_raw_r[k]) begin
          last_raw_nxt[k]    = level[k];
          change_time_nxt[k] = now_ms;
        end else if (elapsed >= debounce_ms) begin
          stable_nxt[k] = level[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stable_r[k]      <= 1'b0;
        last_raw_r[k]    <= 1'b0;
        change_time_r[k] <= '0;
      end else if (step) begin
        stable_r[k]      <= stable_nxt[k];
        last_raw_r[k]    <= last_raw_nxt[k];
        change_time_r[k] <= change_time_nxt[k];
      end
    end
  end

  for (genvar p = 0; p < 4; p++) begin : g_pack
    if (p < NUM_SWITCHES) begin : g_have
      assign limit_bits[p] = stable_nxt[p];
    end else begin : g_none
      assign limit_bits[p] = 1'b0;
    end
  end

endmodule : encpm_debounce

`default_nettype wire

/* rtl/encoder_position_and_limit_monitor_top.sv */
// Top level of the two-axis encoder position and limit-switch monitor.
// Depends on encpm_pkg, encpm_axis and encpm_debounce.
`default_nettype none

// The monitor takes one request per clock while its result register can drain, and
// returns exactly one result per request, in order. A request passes an input
// register and a single pass of state-update logic (a 32-bit position add, a
// 32-bit elevation subtract and four parallel 32-bit time compares) into the
// result register, from which it leaves when out_tready is high; the sustained
// rate is one request per cycle, set by that one update pass, while out_tready
// stays high. The input register can still take one request while a finished
// result waits on the output side. The op code travels in in_tuser: 0 samples
// the counters, pins and time stamp, 1 and 2 count azimuth and elevation index
// pulses, 3 clears azimuth tracking. The debounce time in milliseconds is the
// only register, at byte address 0; the user must write it only while the block
// is idle, which the block itself does not enforce; it resets to 10.
module encoder_position_and_limit_monitor_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input requests.
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // From bit 0: az_counter[15:0], el_counter[47:16], switch_pins[51:48],
  // now_ms[83:52], zero padding[87:84].
  input  wire logic [encpm_pkg::IN_TDATA_W-1:0]    in_tdata,
  // op[1:0].
  input  wire logic [1:0]                          in_tuser,
  // Results.
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // From bit 0: az_position[31:0], el_position[63:32], limit_bits[67:64],
  // az_index_count[83:68], el_index_count[99:84], zero padding[103:100].
  output logic [encpm_pkg::OUT_TDATA_W-1:0]        out_tdata,
  // Configuration port.
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [encpm_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [31:0]                         cfg_pwdata,
  output logic [31:0]                              cfg_prdata,
  output logic                                     cfg_pready
);
  import encpm_pkg::*;

  // Configuration register. Only paddr[2] selects the word.
  logic [31:0] debounce_ms_r;
  logic        cfg_write;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr[2] == REG_DEBOUNCE_SEL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms_r <= DEBOUNCE_RESET;
    end else if (cfg_write) begin
      debounce_ms_r <= cfg_pwdata;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_DEBOUNCE_SEL) begin
      cfg_prdata = debounce_ms_r;
    end
  end

  // Input register. It drains whenever the result register can take a result.
  logic  in_valid_r, in_valid_nxt;
  item_t in_item_r;
  item_t in_item;
  logic  in_accept;
  logic  advance;
  logic  load;

  assign in_item.op          = op_t'(in_tuser);
  assign in_item.az_counter  = in_tdata[15:0];
  assign in_item.el_counter  = in_tdata[47:16];
  assign in_item.switch_pins = in_tdata[51:48];
  assign in_item.now_ms      = in_tdata[83:52];

  assign advance   = !out_tvalid || out_tready;
  assign load      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_accept = in_tvalid && in_tready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_accept) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item_r <= in_item;
    end
  end

  // State update: positions and index counts, and the switch debouncers.
  axis_status_t axis_st;
  logic [3:0]   limit_bits;

  encpm_axis u_axis (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (load),
    .item   (in_item_r),
    .status (axis_st)
  );

  encpm_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (load),
    .sample      (in_item_r.op == OP_SAMPLE),
    .switch_pins (in_item_r.switch_pins),
    .now_ms      (in_item_r.now_ms),
    .debounce_ms (debounce_ms_r),
    .limit_bits  (limit_bits)
  );

  // Result register.
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= {4'b0000, axis_st.el_index_count, axis_st.az_index_count,
                     limit_bits, axis_st.el_position, axis_st.az_position};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A held request in the input register must stay put until it moves on.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |=> in_valid_r && $stable(in_item_r))
    else $error("input register lost or changed a waiting request");

  // An azimuth reset always reports a zero azimuth position.
  a_az_reset: assert property (@(posedge clk) disable iff (!rst_n)
    load && (in_item_r.op == OP_AZ_RESET) |=> out_tdata[31:0] == 32'd0)
    else $error("azimuth reset did not clear the position");

  // Requests other than samples leave the debounced switch bits alone.
  a_limits_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load) && load && (in_item_r.op != OP_SAMPLE)
    |=> out_tdata[67:64] == $past(out_tdata[67:64]))
    else $error("limit bits changed on a request that is not a sample");

  // Index pulses advance their counter by exactly one.
  a_az_index: assert property (@(posedge clk) disable iff (!rst_n)
    $past(load) && load && (in_item_r.op == OP_AZ_INDEX)
    |=> out_tdata[83:68] == $past(out_tdata[83:68]) + 16'd1)
    else $error("azimuth index count did not advance by one");

endmodule : encoder_position_and_limit_monitor_top

`default_nettype wire

/* bench/encoder_position_and_limit_monitor_top_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for encoder_position_and_limit_monitor_top: directed and random requests
// are checked against a cycle-free model of the azimuth, elevation and debounce state.
// Depends on encpm_pkg and the monitor RTL.

// One expected result, one field per output.
typedef struct {
  logic [31:0] az_position;
  logic [31:0] el_position;
  logic [3:0]  limit_bits;
  logic [15:0] az_index_count;
  logic [15:0] el_index_count;
} axis_status_expect_t;

// Tracks the monitor state request by request and keeps the results still owed by the block.
class limit_monitor_scoreboard;
  localparam int unsigned MAX_PRINTED = 40;

  logic [31:0] debounce_ms;
  logic [15:0] az_last_count;
  logic [31:0] az_sum;
  logic [31:0] el_held;
  logic [15:0] az_pulses;
  logic [15:0] el_pulses;
  logic        sw_stable    [encpm_pkg::NUM_SWITCHES];
  logic        sw_last_raw  [encpm_pkg::NUM_SWITCHES];
  logic [31:0] sw_change_ms [encpm_pkg::NUM_SWITCHES];
  axis_status_expect_t owed_status_q[$];
  int unsigned mismatches;
  int unsigned results_checked;

  function new();
    int k;
    debounce_ms   = encpm_pkg::DEBOUNCE_RESET;
    az_last_count = encpm_pkg::AZ_MIDPOINT;
    az_sum        = '0;
    el_held       = '0;
    az_pulses     = '0;
    el_pulses     = '0;
    for (k = 0; k < encpm_pkg::NUM_SWITCHES; k++) begin
      sw_stable[k]    = 1'b0;
      sw_last_raw[k]  = 1'b0;
      sw_change_ms[k] = '0;
    end
    mismatches      = 0;
    results_checked = 0;
  endfunction

  // Advances the state by one accepted request and queues the result it must produce.
  function void note_request(encpm_pkg::op_t op, logic [15:0] az_count, logic [31:0] el_count,
                             logic [3:0] pins, logic [31:0] now_ms);
    int                  k;
    logic [15:0]         delta;
    logic [31:0]         elapsed;
    logic                level;
    axis_status_expect_t status;
    case (op)
      encpm_pkg::OP_SAMPLE: begin
        delta         = az_count - az_last_count;
        az_last_count = az_count;
        az_sum        = az_sum + {{16{delta[15]}}, delta};
        el_held       = encpm_pkg::EL_MIDPOINT - el_count;
        for (k = 0; k < encpm_pkg::NUM_SWITCHES; k++) begin
          level = (k < encpm_pkg::PIN_COUNT) ? ~pins[k] : 1'b0;
          elapsed = now_ms - sw_change_ms[k];
          if (level != sw_last_raw[k]) begin
            sw_last_raw[k]  = level;
            sw_change_ms[k] = now_ms;
          end else if (elapsed >= debounce_ms) begin
            sw_stable[k] = level;
          end
        end
      end
      encpm_pkg::OP_AZ_INDEX: az_pulses = az_pulses + 16'd1;
      encpm_pkg::OP_EL_INDEX: el_pulses = el_pulses + 16'd1;
      default: begin
        az_last_count = encpm_pkg::AZ_MIDPOINT;
        az_sum        = '0;
      end
    endcase
    status.az_position    = az_sum;
    status.el_position    = el_held;
    status.limit_bits     = '0;
    status.az_index_count = az_pulses;
    status.el_index_count = el_pulses;
    for (k = 0; k < encpm_pkg::NUM_SWITCHES && k < encpm_pkg::PIN_COUNT; k++)
      status.limit_bits[k] = sw_stable[k];
    owed_status_q.push_back(status);
  endfunction

  task report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_result(logic [encpm_pkg::OUT_TDATA_W-1:0] tdata);
    axis_status_expect_t want;
    if (owed_status_q.size() == 0) begin
      report_mismatch($sformatf("result %h with no request outstanding", tdata));
    end else begin
      want = owed_status_q.pop_front();
      results_checked++;
      if (tdata[31:0] !== want.az_position)
        report_mismatch($sformatf("az_position %h, expected %h", tdata[31:0], want.az_position));
      if (tdata[63:32] !== want.el_position)
        report_mismatch($sformatf("el_position %h, expected %h", tdata[63:32], want.el_position));
      if (tdata[67:64] !== want.limit_bits)
        report_mismatch($sformatf("limit_bits %b, expected %b", tdata[67:64], want.limit_bits));
      if (tdata[83:68] !== want.az_index_count)
        report_mismatch($sformatf("az_index_count %h, expected %h", tdata[83:68],
                                  want.az_index_count));
      if (tdata[99:84] !== want.el_index_count)
        report_mismatch($sformatf("el_index_count %h, expected %h", tdata[99:84],
                                  want.el_index_count));
      if (tdata[103:100] !== 4'h0)
        report_mismatch($sformatf("padding bits %b, expected zero", tdata[103:100]));
    end
  endtask

  function int unsigned owed();
    return owed_status_q.size();
  endfunction
endclass

module encoder_position_and_limit_monitor_top_tb;
  import encpm_pkg::*;

  // The slowest legal run is about 1950 requests, each with random idle stretches on both
  // sides, plus the register accesses; this limit is meant to outlast such a run.
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned PHASE_ITEMS  = 238;
  localparam int unsigned INDEX_BURST  = 16;
  // Register 0 (debounce time) sits at byte address 0.
  localparam logic [CFG_ADDR_W-1:0] ADDR_DEBOUNCE = {REG_DEBOUNCE_SEL, 2'b00};

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // From bit 0: az_counter, el_counter, switch_pins, now_ms, zero padding.
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  // op.
  logic [1:0]             in_tuser  = OP_SAMPLE;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // From bit 0: az_position, el_position, limit_bits, az_index_count, el_index_count, padding.
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_psel    = 1'b0;
  logic                   cfg_penable = 1'b0;
  logic                   cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_paddr   = '0;
  logic [31:0]            cfg_pwdata  = '0;
  logic [31:0]            cfg_prdata;
  logic                   cfg_pready;

  limit_monitor_scoreboard sb;
  int unsigned cycle_count     = 0;
  int unsigned requests_issued = 0;
  // When set, neither side inserts idle cycles.
  bit          no_idle         = 1'b0;

  encoder_position_and_limit_monitor_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Both channels are observed at the rising edge, where everything driven at the previous
  // falling edge has settled. A request updates the model before the result is checked, which
  // cannot matter because a result never leaves in the cycle its request enters.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.note_request(op_t'(in_tuser), in_tdata[15:0], in_tdata[47:16], in_tdata[51:48],
                        in_tdata[83:52]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycle_count, sb.owed());
      $display("encoder_position_and_limit_monitor_top_tb: errors");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    return no_idle ? 0 : $urandom_range(0, 7);
  endfunction

  // Every task below is entered and left at a falling edge, and each one assigns a given signal
  // at most once per falling edge, so a valid that stays high is never lowered and raised again
  // within one time step.
  task automatic send_request(op_t op, logic [15:0] az_count, logic [31:0] el_count,
                              logic [3:0] pins, logic [31:0] now_ms);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'h0, now_ms, pins, el_count, az_count};
    do @(posedge clk); while (!in_tready);
    requests_issued++;
    @(negedge clk);
  endtask

  // Drops the input valid and waits until every request has produced its result. Since every
  // request yields a result, the block is idle once nothing is owed.
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One APB transfer: a setup phase, then an access phase that completes on pready.
  task automatic cfg_access(bit is_write, logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= ADDR_DEBOUNCE;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // Drains the block, writes the debounce time, and reads it back.
  task automatic set_debounce(logic [31:0] value);
    logic [31:0] readback;
    wait_for_results();
    cfg_access(1'b1, value, readback);
    sb.debounce_ms = value;
    cfg_access(1'b0, '0, readback);
    if (readback !== value)
      sb.report_mismatch($sformatf("debounce_ms read %h after writing %h", readback, value));
  endtask

  // Receiver: holds tready low for a random stretch before taking each result.
  initial begin
    int unsigned stall;
    @(posedge rst_n);
    forever begin
      stall = idle_draw();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  initial begin
    logic [31:0] readback;
    logic [31:0] phase_setting [PHASES];
    logic [15:0] walk_az;
    logic [31:0] walk_now;
    logic [3:0]  walk_pins;
    logic [31:0] step;
    op_t         op;
    int unsigned phase;
    int unsigned n;
    int unsigned pick;

    sb = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The debounce register must come out of reset at 10 ms.
    cfg_access(1'b0, '0, readback);
    if (readback !== DEBOUNCE_RESET)
      sb.report_mismatch($sformatf("debounce_ms reset value %h", readback));

    // Directed part, reset debounce of 10 ms. Pins all high means nothing is triggered.
    send_request(OP_SAMPLE, 16'h8000, 32'h8000_0000, 4'hF, 32'd0);
    // Largest positive azimuth step; an elevation counter of 0 gives the most negative position.
    // Every switch goes active, which only restarts its timer.
    send_request(OP_SAMPLE, 16'hFFFF, 32'h0000_0000, 4'h0, 32'd1);
    // Counter wraps upward by one; only 4 ms have passed, so nothing is stable yet.
    send_request(OP_SAMPLE, 16'h0000, 32'hFFFF_FFFF, 4'h0, 32'd5);
    // Exactly 10 ms held: all four switches become stable. The step is the most negative one.
    send_request(OP_SAMPLE, 16'h8000, 32'h0000_0001, 4'h0, 32'd11);
    // Non-sample requests carry junk that must be ignored.
    send_request(OP_AZ_INDEX, 16'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(OP_EL_INDEX, 16'($urandom), $urandom, 4'($urandom), $urandom);
    send_request(OP_AZ_RESET, 16'($urandom), $urandom, 4'($urandom), $urandom);
    // After the azimuth reset the step is taken from the midpoint again. Two switches release
    // near the top of the time range and settle after the millisecond counter wraps.
    send_request(OP_SAMPLE, 16'h7FFF, 32'h7FFF_FFFF, 4'h5, 32'hFFFF_FFF0);
    send_request(OP_SAMPLE, 16'h7FFF, 32'h8000_0000, 4'h5, 32'h0000_0005);

    // A zero debounce time still needs one unchanged sample before the switch follows.
    set_debounce(32'd0);
    send_request(OP_SAMPLE, 16'h1234, 32'h0000_FFFF, 4'hF, 32'd100);
    send_request(OP_SAMPLE, 16'h1234, 32'hFFFF_0000, 4'hF, 32'd100);

    // The longest debounce time is met only by an elapsed time of all ones.
    set_debounce(32'hFFFF_FFFF);
    send_request(OP_SAMPLE, 16'hFFFF, 32'hAAAA_5555, 4'h0, 32'd200);
    send_request(OP_SAMPLE, 16'hFFFF, 32'h5555_AAAA, 4'h0, 32'd300);
    send_request(OP_SAMPLE, 16'hFFFF, 32'h5555_AAAA, 4'h0, 32'd199);

    // A burst of index pulses on both axes, back to back.
    no_idle = 1'b1;
    for (n = 0; n < INDEX_BURST; n++) begin
      send_request(OP_AZ_INDEX, 16'($urandom), $urandom, 4'($urandom), $urandom);
      send_request(OP_EL_INDEX, 16'($urandom), $urandom, 4'($urandom), $urandom);
    end

    // Random phases, each under its own debounce time. Samples mostly follow a plausible history:
    // the azimuth counter walks in small steps, time moves forward in steps comparable to the
    // debounce time and pins change now and then, so switches really settle and release. A few
    // samples jump anywhere to reach every bit of every field.
    phase_setting = '{32'd10, 32'd0, 32'd1, 32'd5, 32'd0, 32'hFFFF_FFFF, 32'd3, 32'd10};
    phase_setting[4] = $urandom_range(11, 2000);
    walk_az   = 16'($urandom);
    walk_now  = $urandom;
    walk_pins = 4'($urandom);
    for (phase = 0; phase < PHASES; phase++) begin
      set_debounce(phase_setting[phase]);
      no_idle = (phase % 3 == 2);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(0, 19);
        if (pick < 14)       op = OP_SAMPLE;
        else if (pick < 16)  op = OP_AZ_INDEX;
        else if (pick < 18)  op = OP_EL_INDEX;
        else                 op = OP_AZ_RESET;
        if (op != OP_SAMPLE) begin
          send_request(op, 16'($urandom), $urandom, 4'($urandom), $urandom);
        end else begin
          if ($urandom_range(0, 7) == 0) walk_az = 16'($urandom);
          else                           walk_az = 16'(walk_az + $urandom_range(0, 64) - 32);
          pick = $urandom_range(0, 15);
          if (pick == 0)      walk_pins = 4'($urandom);
          else if (pick < 3)  walk_pins = walk_pins ^ (4'h1 << $urandom_range(0, 3));
          pick = $urandom_range(0, 15);
          if (phase_setting[phase] > 32'd100_000) step = $urandom;
          else                                   step = $urandom_range(0, phase_setting[phase] / 2 + 2);
          if (pick == 0)      walk_now = $urandom;
          else if (pick > 1)  walk_now = walk_now + step;
          send_request(OP_SAMPLE, walk_az, $urandom, walk_pins, walk_now);
        end
      end
    end

    // Let the pipeline empty and watch a little longer for any stray result.
    wait_for_results();
    repeat (8) @(posedge clk);

    $display("Ran %0d requests and checked %0d results over %0d debounce settings,",
             requests_issued, sb.results_checked, PHASES + 3);
    $display("with back-to-back index pulses and debounce times from zero to the 32-bit maximum.");
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("encoder_position_and_limit_monitor_top_tb: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.owed());
      $display("encoder_position_and_limit_monitor_top_tb: errors");
    end
    $finish;
  end

endmodule
